>>> src/pwm_sdb_pkg.sv
// ----------------------------------------------------------------------------
// pwm_sdb_pkg
// Shared widths, codes, types and constant tables of the dimmer level bank.
// ----------------------------------------------------------------------------
package pwm_sdb_pkg;

    localparam int UNITS_DEF    = 5;
    localparam int CHANNELS_DEF = 16;

    localparam int LEVEL_W    = 13;
    localparam int CMD_W      = 2;
    localparam int UNIT_PW    = 3;
    localparam int CH_PW      = 4;
    localparam int SIZE_PW    = 5;
    localparam int PCT_W      = 7;
    localparam int DIV_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int QUEUE_DEPTH = 2;

    // percent * absolute_max, then divide by 100 through a reciprocal
    localparam int                PROD_W    = PCT_W + LEVEL_W;
    localparam logic [PCT_W-1:0]  PCT_FULL  = 7'd100;
    localparam int                PCT_SHIFT = 26;
    localparam logic [PROD_W-1:0] PCT_RECIP = 20'd671089;

    // level / divisor as level * ceil(2^17 / divisor) >> 17, exact for 13-bit levels
    localparam int RECIP_W   = 18;
    localparam int DIV_SHIFT = 17;
    localparam logic [RECIP_W-1:0] DIV_RECIP [16] = '{
        18'd131072, 18'd131072, 18'd65536, 18'd43691,
        18'd32768,  18'd26215,  18'd21846, 18'd18725,
        18'd16384,  18'd14564,  18'd13108, 18'd11916,
        18'd10923,  18'd10083,  18'd9363,  18'd8739
    };

    localparam logic [UNIT_PW-1:0] BATT_UNIT_RST  = 3'd0;
    localparam logic [DIV_W-1:0]   BATT_DIV_RST   = 4'd2;
    localparam logic [LEVEL_W-1:0] BATT_FLOOR_RST = 13'd200;
    localparam logic [LEVEL_W-1:0] LEVEL_CAP_RST  = 13'h1000;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET   = 2'd0,
        CMD_FORCE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_RSVD  = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BATT_UNIT  = 3'd0,
        CFG_BATT_DIV   = 3'd1,
        CFG_BATT_FLOOR = 3'd2,
        CFG_CUR_LIMIT  = 3'd3,
        CFG_ABS_MAX    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [UNIT_PW-1:0] batt_unit;
        logic [DIV_W-1:0]   batt_div;
        logic [LEVEL_W-1:0] batt_floor;
        logic [LEVEL_W-1:0] cur_limit;
        logic [LEVEL_W-1:0] abs_max;
    } cfg_t;

    typedef struct packed {
        logic               flush;
        logic [UNIT_PW-1:0] unit;
        logic [CH_PW-1:0]   channel;
        logic [LEVEL_W-1:0] level;
    } op_t;

endpackage

>>> src/pwm_sdb_front.sv
// ----------------------------------------------------------------------------
// pwm_sdb_front
// Accepts items, drops those with nothing to do, and computes the derated,
// clamped level of set and override items in a three-stage pipeline.
// ----------------------------------------------------------------------------
module pwm_sdb_front #(
    parameter int UNITS    = pwm_sdb_pkg::UNITS_DEF,
    parameter int CHANNELS = pwm_sdb_pkg::CHANNELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pwm_sdb_pkg::cfg_t                 cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pwm_sdb_pkg::CMD_W-1:0]     s_cmd,
    input  logic [pwm_sdb_pkg::UNIT_PW-1:0]   s_unit,
    input  logic [pwm_sdb_pkg::CH_PW-1:0]     s_channel,
    input  logic [pwm_sdb_pkg::LEVEL_W-1:0]   s_amount,
    input  logic [pwm_sdb_pkg::PCT_W-1:0]     s_percent,
    input  logic                              s_on_batt,
    output logic                              op_valid,
    input  logic                              op_ready,
    output pwm_sdb_pkg::op_t                  op_data
);
    import pwm_sdb_pkg::*;

    localparam int DPROD_W = 2 * PROD_W;
    localparam int QPROD_W = LEVEL_W + RECIP_W;

    cmd_t               cmd_in;
    logic               keep;
    logic [PCT_W-1:0]   pct_c;
    logic [PROD_W-1:0]  prod_in;
    logic [DPROD_W-1:0] pct_wide;
    logic [LEVEL_W-1:0] raw_in;
    logic [QPROD_W-1:0] div_wide;
    logic [LEVEL_W-1:0] lvl;
    logic               en1, en2, en3;

    logic               s1_v_reg, s2_v_reg, s3_v_reg;
    logic               s1_flush_reg, s2_flush_reg, s3_flush_reg;
    logic               s1_force_reg, s2_force_reg, s3_force_reg;
    logic               s1_batt_reg, s2_batt_reg, s3_batt_reg;
    logic [UNIT_PW-1:0] s1_unit_reg, s2_unit_reg, s3_unit_reg;
    logic [CH_PW-1:0]   s1_ch_reg, s2_ch_reg, s3_ch_reg;
    logic [LEVEL_W-1:0] s1_amount_reg;
    logic [PROD_W-1:0]  s1_prod_reg;
    logic [LEVEL_W-1:0] s2_raw_reg, s3_raw_reg;
    logic [LEVEL_W-1:0] s3_quot_reg;

    assign cmd_in = cmd_t'(s_cmd);

    always_comb begin
        keep = 1'b0;
        if (int'(s_unit) < UNITS) begin
            case (cmd_in)
                CMD_SET, CMD_FORCE: keep = int'(s_channel) < CHANNELS;
                CMD_FLUSH:          keep = 1'b1;
                default:            keep = 1'b0;
            endcase
        end
    end

    assign pct_c   = (s_percent > PCT_FULL) ? PCT_FULL : s_percent;
    assign prod_in = PROD_W'(pct_c) * PROD_W'(cfg.abs_max);

    assign pct_wide = DPROD_W'(s1_prod_reg) * DPROD_W'(PCT_RECIP);
    assign raw_in   = s1_force_reg ? pct_wide[PCT_SHIFT +: LEVEL_W] : s1_amount_reg;

    assign div_wide = QPROD_W'(s2_raw_reg) * QPROD_W'(DIV_RECIP[cfg.batt_div]);

    always_comb begin
        lvl = s3_raw_reg;
        if (s3_raw_reg != '0 && s3_batt_reg) begin
            if (s3_unit_reg != cfg.batt_unit) begin
                lvl = '0;
            end else if (s3_raw_reg > cfg.batt_floor) begin
                lvl = (s3_quot_reg < cfg.batt_floor) ? cfg.batt_floor : s3_quot_reg;
            end
        end
        if (!s3_force_reg && cfg.cur_limit < lvl) begin
            lvl = cfg.cur_limit;
        end
        if (cfg.abs_max < lvl) begin
            lvl = cfg.abs_max;
        end
    end

    assign en3     = !s3_v_reg || op_ready;
    assign en2     = !s2_v_reg || en3;
    assign en1     = !s1_v_reg || en2;
    assign s_ready = en1;

    assign op_valid = s3_v_reg;
    assign op_data  = '{flush: s3_flush_reg, unit: s3_unit_reg, channel: s3_ch_reg, level: lvl};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end else begin
            if (en1) s1_v_reg <= s_valid && keep;
            if (en2) s2_v_reg <= s1_v_reg;
            if (en3) s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_flush_reg  <= cmd_in == CMD_FLUSH;
            s1_force_reg  <= cmd_in == CMD_FORCE;
            s1_batt_reg   <= s_on_batt;
            s1_unit_reg   <= s_unit;
            s1_ch_reg     <= s_channel;
            s1_amount_reg <= s_amount;
            s1_prod_reg   <= prod_in;
        end
        if (en2) begin
            s2_flush_reg <= s1_flush_reg;
            s2_force_reg <= s1_force_reg;
            s2_batt_reg  <= s1_batt_reg;
            s2_unit_reg  <= s1_unit_reg;
            s2_ch_reg    <= s1_ch_reg;
            s2_raw_reg   <= raw_in;
        end
        if (en3) begin
            s3_flush_reg <= s2_flush_reg;
            s3_force_reg <= s2_force_reg;
            s3_batt_reg  <= s2_batt_reg;
            s3_unit_reg  <= s2_unit_reg;
            s3_ch_reg    <= s2_ch_reg;
            s3_raw_reg   <= s2_raw_reg;
            s3_quot_reg  <= div_wide[DIV_SHIFT +: LEVEL_W];
        end
    end

endmodule

>>> src/pwm_sdb_fifo.sv
// ----------------------------------------------------------------------------
// pwm_sdb_fifo
// Short operation queue between the front pipeline and the back sequencer.
// ----------------------------------------------------------------------------
module pwm_sdb_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  pwm_sdb_pkg::op_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pwm_sdb_pkg::op_t out_data
);
    import pwm_sdb_pkg::*;

    // depth is a power of two, pointers wrap on their own
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    op_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready  = cnt_reg != (PW+1)'(QUEUE_DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

>>> src/pwm_sdb_back.sv
// ----------------------------------------------------------------------------
// pwm_sdb_back
// Holds live and committed levels, writes set results, and runs flushes:
// a scan for the changed window, then one result item per channel in it.
// ----------------------------------------------------------------------------
module pwm_sdb_back #(
    parameter int UNITS    = pwm_sdb_pkg::UNITS_DEF,
    parameter int CHANNELS = pwm_sdb_pkg::CHANNELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            op_valid,
    output logic                            op_ready,
    input  pwm_sdb_pkg::op_t                op_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [pwm_sdb_pkg::UNIT_PW-1:0] m_out_unit,
    output logic [pwm_sdb_pkg::CH_PW-1:0]   m_window_offset,
    output logic [pwm_sdb_pkg::SIZE_PW-1:0] m_window_size,
    output logic [pwm_sdb_pkg::CH_PW-1:0]   m_out_channel,
    output logic [pwm_sdb_pkg::LEVEL_W-1:0] m_level,
    output logic                            m_last
);
    import pwm_sdb_pkg::*;

    localparam int DEPTH = UNITS * CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(CHANNELS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD,
        ST_LD,
        ST_OUT
    } state_t;

    function automatic logic [AW-1:0] addr_of(input int u, input int c);
        return AW'(u * CHANNELS + c);
    endfunction

    state_t             state_reg, state_next;
    logic [UNIT_PW-1:0] unit_reg, unit_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               cmp_v_reg, cmp_v_next;
    logic [CIW-1:0]     cmp_idx_reg, cmp_idx_next;
    logic               found_reg, found_next;
    logic [CIW-1:0]     first_reg, first_next;
    logic [CIW-1:0]     last_reg, last_next;
    logic [CIW-1:0]     cur_reg, cur_next;
    logic [SIZE_PW-1:0] size_reg, size_next;
    logic               m_valid_reg, m_valid_next;
    logic [LEVEL_W-1:0] m_level_reg, m_level_next;
    logic               m_last_reg, m_last_next;

    logic [LEVEL_W-1:0] live_mem [DEPTH];
    logic [LEVEL_W-1:0] comm_mem [DEPTH];
    logic [DEPTH-1:0]   live_vld_reg, comm_vld_reg;
    logic [LEVEL_W-1:0] live_rd_reg, comm_rd_reg;
    logic               live_rv_reg, comm_rv_reg;
    logic [LEVEL_W-1:0] live_lvl, comm_lvl;

    logic               live_we, comm_we;
    logic [AW-1:0]      live_waddr, comm_waddr, live_raddr, comm_raddr, scan_addr;
    logic [LEVEL_W-1:0] live_wdata, comm_wdata;
    logic               diff;

    // storage; an entry never written reads as zero
    always_ff @(posedge aclk) begin
        if (live_we) live_mem[live_waddr] <= live_wdata;
        if (comm_we) comm_mem[comm_waddr] <= comm_wdata;
        live_rd_reg <= live_mem[live_raddr];
        comm_rd_reg <= comm_mem[comm_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_vld_reg <= '0;
            comm_vld_reg <= '0;
            live_rv_reg  <= 1'b0;
            comm_rv_reg  <= 1'b0;
        end else begin
            if (live_we) live_vld_reg[live_waddr] <= 1'b1;
            if (comm_we) comm_vld_reg[comm_waddr] <= 1'b1;
            live_rv_reg <= live_vld_reg[live_raddr];
            comm_rv_reg <= comm_vld_reg[comm_raddr];
        end
    end

    assign live_lvl = live_rv_reg ? live_rd_reg : '0;
    assign comm_lvl = comm_rv_reg ? comm_rd_reg : '0;

    assign scan_addr = (int'(idx_reg) < CHANNELS) ? addr_of(int'(unit_reg), int'(idx_reg))
                                                 : addr_of(int'(unit_reg), 0);
    assign diff      = cmp_v_reg && (live_lvl != comm_lvl);

    always_comb begin
        state_next   = state_reg;
        unit_next    = unit_reg;
        idx_next     = idx_reg;
        cmp_v_next   = cmp_v_reg;
        cmp_idx_next = cmp_idx_reg;
        found_next   = found_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        cur_next     = cur_reg;
        size_next    = size_reg;
        m_valid_next = m_valid_reg;
        m_level_next = m_level_reg;
        m_last_next  = m_last_reg;
        op_ready     = 1'b0;
        live_we      = 1'b0;
        live_waddr   = addr_of(int'(op_data.unit), int'(op_data.channel));
        live_wdata   = op_data.level;
        comm_we      = 1'b0;
        comm_waddr   = addr_of(int'(unit_reg), int'(cur_reg));
        comm_wdata   = live_lvl;
        live_raddr   = addr_of(int'(unit_reg), int'(cur_reg));
        comm_raddr   = scan_addr;

        case (state_reg)
            ST_IDLE: begin
                op_ready = 1'b1;
                if (op_valid) begin
                    if (op_data.flush) begin
                        unit_next  = op_data.unit;
                        idx_next   = '0;
                        cmp_v_next = 1'b0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end else begin
                        live_we = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                live_raddr = scan_addr;
                if (diff) begin
                    if (!found_reg) first_next = cmp_idx_reg;
                    last_next  = cmp_idx_reg;
                    found_next = 1'b1;
                end
                if (int'(idx_reg) < CHANNELS) begin
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = idx_reg[CIW-1:0];
                    idx_next     = idx_reg + 1'b1;
                end else begin
                    cmp_v_next = 1'b0;
                    if (found_next) begin
                        cur_next   = first_next;
                        size_next  = SIZE_PW'(int'(last_next) - int'(first_next) + 1);
                        state_next = ST_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_LD;
            end
            ST_LD: begin
                m_valid_next = 1'b1;
                m_level_next = live_lvl;
                m_last_next  = cur_reg == last_reg;
                comm_we      = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        cur_next   = cur_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cmp_v_reg   <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_v_reg   <= cmp_v_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        unit_reg    <= unit_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        first_reg   <= first_next;
        last_reg    <= last_next;
        cur_reg     <= cur_next;
        size_reg    <= size_next;
        m_level_reg <= m_level_next;
        m_last_reg  <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_unit      = unit_reg;
    assign m_window_offset = CH_PW'(first_reg);
    assign m_window_size   = size_reg;
    assign m_out_channel   = CH_PW'(cur_reg);
    assign m_level         = m_level_reg;
    assign m_last          = m_last_reg;

endmodule

>>> src/pwm_shadow_dimmer_bank.sv
// ----------------------------------------------------------------------------
// pwm_shadow_dimmer_bank
// Dimmer level bank for several PWM units: derated and clamped level writes,
// and flushes that send and commit the window of changed channels.
//
//   port group   handshake          payload
//   s_*          s_valid/s_ready    cmd, unit, channel, amount, percent, on_batt
//   m_*          m_valid/m_ready    out_unit, window_offset, window_size,
//                                   out_channel, level, last
//   cfg_*        cfg_we             cfg_index, cfg_wdata
//
// Set and override items: one per cycle, unless the queue is full, through a 3-stage
// level pipeline, then a queue entry, then the live store write in the back sequencer.
// Flush: a scan of live against committed through one read port per memory, then
// read, load and output states per result item, output held through any m_ready stall.
// The 2-entry queue lets the front keep accepting while the back is busy, until it fills.
// Reset: synchronous, active low; storage reads as zero until written.
// ----------------------------------------------------------------------------
module pwm_shadow_dimmer_bank #(
    parameter int UNITS    = pwm_sdb_pkg::UNITS_DEF,
    parameter int CHANNELS = pwm_sdb_pkg::CHANNELS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [pwm_sdb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pwm_sdb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [pwm_sdb_pkg::CMD_W-1:0]      s_cmd,
    input  logic [pwm_sdb_pkg::UNIT_PW-1:0]    s_unit,
    input  logic [pwm_sdb_pkg::CH_PW-1:0]      s_channel,
    input  logic [pwm_sdb_pkg::LEVEL_W-1:0]    s_amount,
    input  logic [pwm_sdb_pkg::PCT_W-1:0]      s_percent,
    input  logic                               s_on_batt,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [pwm_sdb_pkg::UNIT_PW-1:0]    m_out_unit,
    output logic [pwm_sdb_pkg::CH_PW-1:0]      m_window_offset,
    output logic [pwm_sdb_pkg::SIZE_PW-1:0]    m_window_size,
    output logic [pwm_sdb_pkg::CH_PW-1:0]      m_out_channel,
    output logic [pwm_sdb_pkg::LEVEL_W-1:0]    m_level,
    output logic                               m_last
);
    import pwm_sdb_pkg::*;

    cfg_t cfg_reg;
    logic front_valid, front_ready, back_valid, back_ready;
    op_t  front_op, back_op;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.batt_unit  <= BATT_UNIT_RST;
            cfg_reg.batt_div   <= BATT_DIV_RST;
            cfg_reg.batt_floor <= BATT_FLOOR_RST;
            cfg_reg.cur_limit  <= LEVEL_CAP_RST;
            cfg_reg.abs_max    <= LEVEL_CAP_RST;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_BATT_UNIT:  cfg_reg.batt_unit  <= cfg_wdata[UNIT_PW-1:0];
                CFG_BATT_DIV:   cfg_reg.batt_div   <= cfg_wdata[DIV_W-1:0];
                CFG_BATT_FLOOR: cfg_reg.batt_floor <= cfg_wdata[LEVEL_W-1:0];
                CFG_CUR_LIMIT:  cfg_reg.cur_limit  <= cfg_wdata[LEVEL_W-1:0];
                CFG_ABS_MAX:    cfg_reg.abs_max    <= cfg_wdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    pwm_sdb_front #(
        .UNITS    (UNITS),
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_unit       (s_unit),
        .s_channel    (s_channel),
        .s_amount     (s_amount),
        .s_percent    (s_percent),
        .s_on_batt    (s_on_batt),
        .op_valid     (front_valid),
        .op_ready     (front_ready),
        .op_data      (front_op)
    );

    pwm_sdb_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_op),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_op)
    );

    pwm_sdb_back #(
        .UNITS    (UNITS),
        .CHANNELS (CHANNELS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .op_valid        (back_valid),
        .op_ready        (back_ready),
        .op_data         (back_op),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_unit      (m_out_unit),
        .m_window_offset (m_window_offset),
        .m_window_size   (m_window_size),
        .m_out_channel   (m_out_channel),
        .m_level         (m_level),
        .m_last          (m_last)
    );

endmodule

>>> src/pwm_sdb_checker.sv
// ----------------------------------------------------------------------------
// pwm_sdb_checker
// Port-level checks of the result burst, bound to the top level.
// ----------------------------------------------------------------------------
module pwm_sdb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [pwm_sdb_pkg::CH_PW-1:0]   m_window_offset,
    input logic [pwm_sdb_pkg::SIZE_PW-1:0] m_window_size,
    input logic [pwm_sdb_pkg::CH_PW-1:0]   m_out_channel,
    input logic [pwm_sdb_pkg::LEVEL_W-1:0] m_level,
    input logic                            m_last
);
    import pwm_sdb_pkg::*;

    // stalled item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level) && $stable(m_out_channel))
        else $error("result item changed while stalled");

    // channel lies inside its window
    a_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_channel >= m_window_offset) &&
                    (SIZE_PW'(m_out_channel) < SIZE_PW'(m_window_offset) + m_window_size))
        else $error("result channel outside window");

    // last flag marks the window end
    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |->
            (SIZE_PW'(m_out_channel) + SIZE_PW'(1) == SIZE_PW'(m_window_offset) + m_window_size))
        else $error("last flag not on final window channel");

    // each item is refetched, so no two accepts back to back
    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("result valid right after accept");

endmodule

bind pwm_shadow_dimmer_bank pwm_sdb_checker u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_window_offset (m_window_offset),
    .m_window_size   (m_window_size),
    .m_out_channel   (m_out_channel),
    .m_level         (m_level),
    .m_last          (m_last)
);
